### rtl/irs_pkg.sv
// ----------------------------------------------------------------------------
// irs_pkg
// Types and codes shared by the I2C register access sequencer.
// ----------------------------------------------------------------------------
package irs_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        PH_INIT     = 4'd0,
        PH_IDLE     = 4'd1,
        PH_CHECK    = 4'd2,
        PH_TRAP     = 4'd3,
        PH_START    = 4'd4,
        PH_SLAVE    = 4'd5,
        PH_DATA     = 4'd6,
        PH_RESTART  = 4'd7,
        PH_LOCATION = 4'd8,
        PH_READ     = 4'd9,
        PH_STOP     = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_ADDR_W = 3'd2,
        ACT_ADDR_R = 3'd3,
        ACT_REG    = 3'd4,
        ACT_SEND   = 3'd5,
        ACT_READ   = 3'd6,
        ACT_STOP   = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] peripheral;
        logic [6:0] slave_address;
        logic [7:0] location_address;
        logic [7:0] write_byte;
        logic       init_done;
        logic       bus_error;
        logic       step_ok;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [2:0] action_peripheral;
        logic [7:0] action_byte;
        logic [1:0] status;
        logic [7:0] read_byte;
    } res_t;

endpackage

### rtl/irs_if.sv
// ----------------------------------------------------------------------------
// irs_if
// Valid/ready channels carrying sequencer requests and results.
// ----------------------------------------------------------------------------
interface irs_req_if;
    logic          valid;
    logic          ready;
    irs_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irs_res_if;
    logic          valid;
    logic          ready;
    irs_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/i2c_register_access_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer
// Steps one-byte I2C register writes and reads over a lower bus engine.
// Pipeline: a request passes the input register, then the result register;
// a held result stalls requests.
// Throughput: one request per cycle unless stalled; one state step per request.
// Reset: rst_n clears all sequencer state to the init phase, outcome busy.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    irs_req_if.sink     request,
    irs_res_if.source   result
);
    import irs_pkg::*;

    logic    stage_valid_reg;
    req_t    stage_data_reg;
    logic    res_valid_reg;
    res_t    res_data_reg;
    logic    advance;

    phase_t  phase_reg, phase_next;
    phase_t  last_reg, last_next;
    logic    rsd_reg, rsd_next;
    logic    write_pending_reg, write_pending_next;
    logic    read_pending_reg, read_pending_next;
    logic [2:0] held_peripheral_reg, held_peripheral_next;
    logic [6:0] held_slave_reg, held_slave_next;
    logic [7:0] held_location_reg, held_location_next;
    logic [7:0] held_data_reg, held_data_next;
    status_t outcome_reg, outcome_next;
    logic [7:0] captured_reg, captured_next;
    action_t act;
    logic [7:0] abyte;
    res_t    res_next;

    assign advance       = !res_valid_reg || result.ready;
    assign request.ready = !stage_valid_reg || advance;
    assign result.valid  = res_valid_reg;
    assign result.data   = res_data_reg;

    always_comb
    begin
        phase_next           = phase_reg;
        last_next            = last_reg;
        rsd_next             = rsd_reg;
        write_pending_next   = write_pending_reg;
        read_pending_next    = read_pending_reg;
        held_peripheral_next = held_peripheral_reg;
        held_slave_next      = held_slave_reg;
        held_location_next   = held_location_reg;
        held_data_next       = held_data_reg;
        outcome_next         = outcome_reg;
        captured_next        = captured_reg;
        act                  = ACT_NONE;
        abyte                = 8'd0;
        case (stage_data_reg.command)
            CMD_WRITE, CMD_READ:
            begin
                held_peripheral_next = stage_data_reg.peripheral;
                held_slave_next      = stage_data_reg.slave_address;
                held_location_next   = stage_data_reg.location_address;
                if (stage_data_reg.command == CMD_WRITE)
                begin
                    held_data_next     = stage_data_reg.write_byte;
                    write_pending_next = 1'b1;
                end
                else
                begin
                    read_pending_next = 1'b1;
                end
            end
            CMD_TICK:
            begin
                case (phase_reg)
                    PH_INIT:
                    begin
                        last_next = PH_INIT;
                        if (stage_data_reg.init_done)
                            phase_next = PH_IDLE;
                    end
                    PH_IDLE:
                    begin
                        last_next = PH_IDLE;
                        if (write_pending_reg || read_pending_reg)
                        begin
                            phase_next   = PH_START;
                            outcome_next = ST_BUSY;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (stage_data_reg.bus_error)
                        begin
                            phase_next = PH_TRAP;
                        end
                        else if (stage_data_reg.step_ok)
                        begin
                            case (last_reg)
                                PH_START, PH_RESTART:
                                    phase_next = PH_SLAVE;
                                PH_SLAVE:
                                begin
                                    if (rsd_reg)
                                    begin
                                        rsd_next   = 1'b0;
                                        phase_next = PH_READ;
                                    end
                                    else
                                    begin
                                        phase_next = PH_LOCATION;
                                    end
                                end
                                PH_LOCATION:
                                begin
                                    if (write_pending_reg)
                                        phase_next = PH_DATA;
                                    else if (read_pending_reg)
                                        phase_next = PH_RESTART;
                                end
                                PH_DATA:
                                    phase_next = PH_STOP;
                                PH_READ:
                                begin
                                    captured_next = stage_data_reg.rx_byte;
                                    phase_next    = PH_STOP;
                                end
                                default:
                                    phase_next = phase_reg;
                            endcase
                        end
                    end
                    PH_TRAP:
                        outcome_next = ST_FAIL;
                    PH_START, PH_RESTART:
                    begin
                        if (phase_reg == PH_RESTART)
                            rsd_next = 1'b1;
                        last_next  = phase_reg;
                        act        = ACT_START;
                        phase_next = PH_CHECK;
                    end
                    PH_SLAVE:
                    begin
                        last_next  = PH_SLAVE;
                        act        = rsd_reg ? ACT_ADDR_R : ACT_ADDR_W;
                        abyte      = {1'b0, held_slave_reg};
                        phase_next = PH_CHECK;
                    end
                    PH_LOCATION:
                    begin
                        last_next  = PH_LOCATION;
                        act        = ACT_REG;
                        abyte      = held_location_reg;
                        phase_next = PH_CHECK;
                    end
                    PH_DATA:
                    begin
                        last_next  = PH_DATA;
                        act        = ACT_SEND;
                        abyte      = held_data_reg;
                        phase_next = PH_CHECK;
                    end
                    PH_READ:
                    begin
                        last_next  = PH_READ;
                        act        = ACT_READ;
                        phase_next = PH_CHECK;
                    end
                    PH_STOP:
                    begin
                        last_next          = PH_STOP;
                        act                = ACT_STOP;
                        phase_next         = PH_IDLE;
                        write_pending_next = 1'b0;
                        read_pending_next  = 1'b0;
                        outcome_next       = ST_OK;
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end
            default:
                act = ACT_NONE;
        endcase

        res_next.bus_action        = act;
        res_next.action_peripheral = (act != ACT_NONE) ? held_peripheral_reg : 3'd0;
        res_next.action_byte       = abyte;
        res_next.status            = outcome_next;
        res_next.read_byte         = captured_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg     <= 1'b0;
            res_valid_reg       <= 1'b0;
            phase_reg           <= PH_INIT;
            last_reg            <= PH_INIT;
            rsd_reg             <= 1'b0;
            write_pending_reg   <= 1'b0;
            read_pending_reg    <= 1'b0;
            held_peripheral_reg <= 3'd0;
            held_slave_reg      <= 7'd0;
            held_location_reg   <= 8'd0;
            held_data_reg       <= 8'd0;
            outcome_reg         <= ST_BUSY;
            captured_reg        <= 8'd0;
        end
        else
        begin
            if (request.ready)
                stage_valid_reg <= request.valid;
            if (advance)
                res_valid_reg <= stage_valid_reg;
            if (advance && stage_valid_reg)
            begin
                phase_reg           <= phase_next;
                last_reg            <= last_next;
                rsd_reg             <= rsd_next;
                write_pending_reg   <= write_pending_next;
                read_pending_reg    <= read_pending_next;
                held_peripheral_reg <= held_peripheral_next;
                held_slave_reg      <= held_slave_next;
                held_location_reg   <= held_location_next;
                held_data_reg       <= held_data_next;
                outcome_reg         <= outcome_next;
                captured_reg        <= captured_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
            stage_data_reg <= request.data;
        if (advance && stage_valid_reg)
            res_data_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_trap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TRAP |=> phase_reg == PH_TRAP)
        else $error("left trap phase");

    a_fail_in_trap: assert property (@(posedge clk) disable iff (!rst_n)
        outcome_reg == ST_FAIL |-> phase_reg == PH_TRAP)
        else $error("failure outcome outside trap");

    a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(write_pending_reg) || $fell(read_pending_reg) |->
            $past(phase_reg) == PH_STOP && phase_reg == PH_IDLE)
        else $error("pending flag cleared outside stop");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.bus_action == ACT_NONE |->
            res_data_reg.action_peripheral == 3'd0 && res_data_reg.action_byte == 8'd0)
        else $error("fields set without bus action");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && res_valid_reg && !result.ready |-> !request.ready)
        else $error("request taken while pipeline stalled");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C register access sequencer. A queue of
// requests (directed bring-up, random write/read transactions with engine
// status noise, then a bus error into the trap) feeds a valid/ready driver.
// Each accepted request is stepped through a local sequencer model and the
// monitor compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import irs_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS    = 650;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_AT     = 120;
    localparam int HOLD_OFF_CYCLES = 90;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        phase_t     phase;
        phase_t     last_phase;
        logic       restart_done;
        logic       write_pend;
        logic       read_pend;
        logic [2:0] periph;
        logic [6:0] slave;
        logic [7:0] location;
        logic [7:0] data;
        status_t    outcome;
        logic [7:0] captured;
    } seq_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    irs_req_if request_ch();
    irs_res_if result_ch();

    i2c_register_access_sequencer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    always #6 clk = ~clk;

    req_t       pending_q[$];
    res_t       expected_q[$];
    seq_state_t gen_state;
    seq_state_t model_state;

    int accepted_n  = 0;
    int total_items = 1;
    int mismatches  = 0;
    int results_n   = 0;
    int stops_n     = 0;
    int reads_n     = 0;
    int fails_n     = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int cycles      = 0;

    function automatic res_t sequencer_step(inout seq_state_t s, input req_t r);
        action_t    act;
        logic [7:0] abyte;
        res_t       o;
        act   = ACT_NONE;
        abyte = 8'd0;
        if (r.command == CMD_WRITE || r.command == CMD_READ)
        begin
            s.periph   = r.peripheral;
            s.slave    = r.slave_address;
            s.location = r.location_address;
            if (r.command == CMD_WRITE)
            begin
                s.data       = r.write_byte;
                s.write_pend = 1'b1;
            end
            else
                s.read_pend = 1'b1;
        end
        else if (r.command == CMD_TICK)
        begin
            case (s.phase)
                PH_INIT:
                begin
                    s.last_phase = PH_INIT;
                    if (r.init_done)
                        s.phase = PH_IDLE;
                end
                PH_IDLE:
                begin
                    s.last_phase = PH_IDLE;
                    if (s.write_pend || s.read_pend)
                    begin
                        s.phase   = PH_START;
                        s.outcome = ST_BUSY;
                    end
                end
                PH_CHECK:
                begin
                    if (r.bus_error)
                        s.phase = PH_TRAP;
                    else if (r.step_ok)
                    begin
                        case (s.last_phase)
                            PH_START, PH_RESTART:
                                s.phase = PH_SLAVE;
                            PH_SLAVE:
                                if (s.restart_done)
                                begin
                                    s.restart_done = 1'b0;
                                    s.phase = PH_READ;
                                end
                                else
                                    s.phase = PH_LOCATION;
                            PH_LOCATION:
                                if (s.write_pend)
                                    s.phase = PH_DATA;
                                else if (s.read_pend)
                                    s.phase = PH_RESTART;
                            PH_DATA:
                                s.phase = PH_STOP;
                            PH_READ:
                            begin
                                s.captured = r.rx_byte;
                                s.phase = PH_STOP;
                            end
                            default: ;
                        endcase
                    end
                end
                PH_TRAP:
                    s.outcome = ST_FAIL;
                PH_START, PH_RESTART:
                begin
                    if (s.phase == PH_RESTART)
                        s.restart_done = 1'b1;
                    s.last_phase = s.phase;
                    act = ACT_START;
                    s.phase = PH_CHECK;
                end
                PH_SLAVE:
                begin
                    s.last_phase = PH_SLAVE;
                    act = s.restart_done ? ACT_ADDR_R : ACT_ADDR_W;
                    abyte = {1'b0, s.slave};
                    s.phase = PH_CHECK;
                end
                PH_LOCATION:
                begin
                    s.last_phase = PH_LOCATION;
                    act = ACT_REG;
                    abyte = s.location;
                    s.phase = PH_CHECK;
                end
                PH_DATA:
                begin
                    s.last_phase = PH_DATA;
                    act = ACT_SEND;
                    abyte = s.data;
                    s.phase = PH_CHECK;
                end
                PH_READ:
                begin
                    s.last_phase = PH_READ;
                    act = ACT_READ;
                    s.phase = PH_CHECK;
                end
                PH_STOP:
                begin
                    s.last_phase = PH_STOP;
                    act = ACT_STOP;
                    s.phase = PH_IDLE;
                    s.write_pend = 1'b0;
                    s.read_pend = 1'b0;
                    s.outcome = ST_OK;
                end
                default: ;
            endcase
        end
        o.bus_action        = act;
        o.action_peripheral = (act != ACT_NONE) ? s.periph : 3'd0;
        o.action_byte       = abyte;
        o.status            = s.outcome;
        o.read_byte         = s.captured;
        return o;
    endfunction

    function automatic req_t random_request(input logic [1:0] cmd);
        req_t r;
        r.command          = cmd;
        r.peripheral       = 3'($urandom_range(7));
        r.slave_address    = 7'($urandom_range(127));
        r.location_address = 8'($urandom_range(255));
        r.write_byte       = 8'($urandom_range(255));
        r.init_done        = 1'($urandom_range(1));
        r.bus_error        = 1'($urandom_range(1));
        r.step_ok          = 1'($urandom_range(1));
        r.rx_byte          = 8'($urandom_range(255));
        return r;
    endfunction

    function automatic req_t tick_request(input logic ok, input logic err);
        req_t r;
        r = random_request(CMD_TICK);
        r.step_ok   = ok;
        r.bus_error = err;
        return r;
    endfunction

    task automatic queue_request(input req_t r);
        void'(sequencer_step(gen_state, r));
        pending_q.push_back(r);
    endtask

    // clean engine ticks until the sequence reaches the wanted phase
    task automatic step_until(input phase_t target);
        req_t r;
        while (gen_state.phase != target)
        begin
            r = tick_request(1'b1, 1'b0);
            r.init_done = 1'b1;
            queue_request(r);
        end
    endtask

    function automatic int sender_idle_pct();
        case ((accepted_n * 3) / total_items)
            0:       return 14;
            1:       return 46;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case ((accepted_n * 3) / total_items)
            0:       return 46;
            1:       return 14;
            default: return 0;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_ch.valid && request_ch.ready)
            begin
                expected_q.push_back(sequencer_step(model_state, request_ch.data));
                accepted_n <= accepted_n + 1;
            end
            if (!request_ch.valid || request_ch.ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    request_ch.data  <= pending_q.pop_front();
                    request_ch.valid <= 1'b1;
                end
                else
                    request_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        res_t got;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                results_n++;
                if (expected_q.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: act=%0d per=%0d byte=%02h st=%0d rd=%02h",
                                 got.bus_action, got.action_peripheral, got.action_byte,
                                 got.status, got.read_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.bus_action !== want.bus_action
                        || got.action_peripheral !== want.action_peripheral
                        || got.action_byte !== want.action_byte
                        || got.status !== want.status
                        || got.read_byte !== want.read_byte)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display({"result %0d mismatch: ",
                                      "exp act=%0d per=%0d byte=%02h st=%0d rd=%02h, ",
                                      "got act=%0d per=%0d byte=%02h st=%0d rd=%02h"},
                                     results_n, want.bus_action, want.action_peripheral,
                                     want.action_byte, want.status, want.read_byte,
                                     got.bus_action, got.action_peripheral,
                                     got.action_byte, got.status, got.read_byte);
                        mismatches++;
                    end
                    if (want.bus_action == ACT_STOP)
                        stops_n++;
                    if (want.bus_action == ACT_READ)
                        reads_n++;
                    if (want.status == ST_FAIL)
                        fails_n++;
                end
            end
            if (hold_left > 0)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // one long receiver hold-off so the block backs up into the request side
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && accepted_n >= HOLD_OFF_AT)
        begin
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        req_t r;
        int   counted;
        int   roll;
        request_ch.valid = 1'b0;
        request_ch.data  = '0;
        result_ch.ready  = 1'b0;
        gen_state = '{PH_INIT, PH_INIT, 1'b0, 1'b0, 1'b0, 3'd0, 7'd0, 8'd0, 8'd0,
                      ST_BUSY, 8'd0};
        model_state = gen_state;

        // bring-up: init held low, reserved command, max-field write before init
        r = tick_request(1'b1, 1'b1);
        r.init_done = 1'b0;
        queue_request(r);
        r = '1;
        queue_request(r);
        r = '1;
        r.command = CMD_WRITE;
        queue_request(r);
        step_until(PH_CHECK);
        queue_request(tick_request(1'b0, 1'b0));
        step_until(PH_LOCATION);
        // zero-field read lands mid-write: both pending, data phase wins
        r = '0;
        r.command = CMD_READ;
        queue_request(r);
        step_until(PH_IDLE);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (gen_state.phase == PH_IDLE && roll < 60)
            begin
                r = random_request($urandom_range(1) ? CMD_WRITE : CMD_READ);
                counted++;
            end
            else if (roll < 4)
                r = random_request(CMD_RESERVED);
            else if (roll < 10)
            begin
                r = random_request($urandom_range(1) ? CMD_WRITE : CMD_READ);
                counted++;
            end
            else
            begin
                r = tick_request($urandom_range(99) < 85,
                                 (gen_state.phase == PH_CHECK) ? 1'b0 : 1'($urandom_range(1)));
                counted++;
            end
            queue_request(r);
        end

        // engine error at a status check, then the trap stays put
        queue_request(random_request(CMD_WRITE));
        step_until(PH_CHECK);
        queue_request(tick_request(1'($urandom_range(1)), 1'b1));
        repeat (3)
            queue_request(tick_request(1'($urandom_range(1)), 1'($urandom_range(1))));
        queue_request(random_request(CMD_READ));
        queue_request(random_request(CMD_RESERVED));
        repeat (3)
            queue_request(tick_request(1'b1, 1'b0));

        total_items = pending_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending_q.size() == 0 && !request_ch.valid && expected_q.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests, %0d results checked, %0d mismatches", accepted_n, results_n,
                 mismatches);
        $display("%0d transactions stopped, %0d read-data steps, %0d results in trap",
                 stops_n, reads_n, fails_n);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
